// ----- src/smid_pkg.sv -----
`default_nettype none

package smid_pkg;

  // Number of cells in the table.
  localparam int unsigned CAPACITY = 16;

  // Width of the fill count, wide enough to hold CAPACITY itself.
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Widths of the fields carried on the channels.
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned ENTRY_COUNT_W = 5;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DELETE = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Operation broadcast to every cell.
  typedef struct packed {
    logic do_insert;
    logic do_delete;
  } cell_ctl_t;

  // Where a cell sits relative to the current fill level.
  typedef struct packed {
    logic occupied;
    logic at_end;
  } cell_pos_t;

  // One result word.
  typedef struct packed {
    status_e                  status;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } rsp_t;

endpackage

`default_nettype wire

// ----- src/smid_req_if.sv -----
`default_nettype none

interface smid_req_if
  import smid_pkg::*;
  ();

  logic                      valid;
  logic                      ready;
  req_type_e                 req_type;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink (input valid, input req_type, input value, output ready);

endinterface

`default_nettype wire

// ----- src/smid_rsp_if.sv -----
`default_nettype none

interface smid_rsp_if
  import smid_pkg::*;
  ();

  logic                     valid;
  logic                     ready;
  status_e                  status;
  logic [ENTRY_COUNT_W-1:0] entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink (input valid, input status, input entry_count, output ready);

endinterface

`default_nettype wire

// ----- src/sorted_multiset_insert_delete.sv -----
`default_nettype none

// Channel  Dir  Word fields                Role
// req_i    in   req_type, value            insert or delete one value
// rsp_o    out  status, entry_count        one result word per request
//
// Every cell compares its entry with the request value and shifts to its
// neighbor in the same cycle, so one request is accepted per cycle while
// the result queue has room. The result word reaches rsp_o in the cycle
// after acceptance when no earlier word is still waiting. Reset clears the
// fill count and the result queue; the entries need none. A two-word result
// queue keeps requests flowing while rsp_o is stalled; req_i stalls only
// when both words are waiting.

module sorted_multiset_insert_delete
  import smid_pkg::*;
(
  input  wire      clk_i,
  input  wire      rst_ni,
  smid_req_if.sink req_i,
  smid_rsp_if.source rsp_o
);

  logic [CNT_W-1:0]          count_q, count_d;
  logic                      accept;
  logic                      buf_ready;
  logic                      full;
  logic                      found;
  logic [CAPACITY-1:0]       eq_vec;
  logic [CAPACITY-1:0]       ins_vec;
  logic signed [VALUE_W-1:0] cell_word [CAPACITY];
  cell_ctl_t                 ctl;
  rsp_t                      rsp_word;

  assign req_i.ready = buf_ready;
  assign accept = req_i.valid && buf_ready;
  assign full = (count_q == CNT_W'(CAPACITY));
  assign found = |eq_vec;

  // Decide the operation and the result for the accepted word.
  always_comb begin
    ctl = '0;
    count_d = count_q;
    rsp_word.status = ST_OK;
    if (req_i.req_type == REQ_INSERT) begin
      if (full) begin
        rsp_word.status = ST_FULL;
      end else begin
        ctl.do_insert = accept;
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (count_q == '0) begin
        rsp_word.status = ST_EMPTY;
      end else if (!found) begin
        rsp_word.status = ST_NOT_FOUND;
      end else begin
        ctl.do_delete = accept;
        count_d = count_q - CNT_W'(1);
      end
    end
    rsp_word.entry_count = ENTRY_COUNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // Cells chained left and right; the request value enters at cell 0.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_pos_t                 pos;
    logic                      left_ins;
    logic signed [VALUE_W-1:0] left_word;
    logic signed [VALUE_W-1:0] right_word;

    assign pos.occupied = (CNT_W'(i) < count_q);
    assign pos.at_end = (CNT_W'(i) == count_q);

    if (i == 0) begin : g_first
      assign left_ins = 1'b0;
      assign left_word = req_i.value;
    end else begin : g_inner_left
      assign left_ins = ins_vec[i-1];
      assign left_word = cell_word[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_word = cell_word[i];
    end else begin : g_inner_right
      assign right_word = cell_word[i+1];
    end

    smid_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .pos_i        (pos),
      .value_i      (req_i.value),
      .left_ins_i   (left_ins),
      .left_word_i  (left_word),
      .right_word_i (right_word),
      .ins_here_o   (ins_vec[i]),
      .eq_o         (eq_vec[i]),
      .word_o       (cell_word[i])
    );
  end

  smid_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_word_i (rsp_word),
    .ready_o     (buf_ready),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

// ----- src/smid_cell.sv -----
`default_nettype none

module smid_cell
  import smid_pkg::*;
(
  input  wire                       clk_i,
  input  wire cell_ctl_t            ctl_i,
  input  wire cell_pos_t            pos_i,
  input  wire logic signed [VALUE_W-1:0] value_i,
  input  wire                       left_ins_i,
  input  wire logic signed [VALUE_W-1:0] left_word_i,
  input  wire logic signed [VALUE_W-1:0] right_word_i,
  output logic                      ins_here_o,
  output logic                      eq_o,
  output logic signed [VALUE_W-1:0] word_o
);

  logic signed [VALUE_W-1:0] word_q;
  logic signed [VALUE_W-1:0] word_d;
  logic                      gt;
  logic                      ge;

  // Compare the stored word against the request value.
  assign gt = pos_i.occupied && (word_q > value_i);
  assign ge = pos_i.occupied && (word_q >= value_i);
  assign eq_o = pos_i.occupied && (word_q == value_i);

  // The insert point and everything above it move up; the first free cell joins in.
  assign ins_here_o = gt || pos_i.at_end;

  // Shift right on insert, shift left on delete from the first match onward.
  always_comb begin
    word_d = word_q;
    if (ctl_i.do_insert && ins_here_o) begin
      word_d = left_ins_i ? left_word_i : value_i;
    end else if (ctl_i.do_delete && ge) begin
      word_d = right_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

// ----- src/smid_obuf.sv -----
`default_nettype none

module smid_obuf
  import smid_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        push_i,
  input  wire rsp_t  push_word_i,
  output logic       ready_o,
  smid_rsp_if.source rsp_o
);

  logic head_vld_q, head_vld_d;
  logic skid_vld_q, skid_vld_d;
  rsp_t head_q, head_d;
  rsp_t skid_q, skid_d;
  logic pop;

  assign pop = head_vld_q && rsp_o.ready;
  assign ready_o = !skid_vld_q;

  // Two-entry queue: the head drives the port, the skid slot absorbs a stall.
  always_comb begin
    head_vld_d = head_vld_q;
    skid_vld_d = skid_vld_q;
    head_d = head_q;
    skid_d = skid_q;
    if (pop) begin
      if (skid_vld_q) begin
        head_d = skid_q;
        head_vld_d = 1'b1;
        skid_vld_d = push_i;
        skid_d = push_word_i;
      end else begin
        head_vld_d = push_i;
        head_d = push_word_i;
      end
    end else if (push_i) begin
      if (!head_vld_q) begin
        head_vld_d = 1'b1;
        head_d = push_word_i;
      end else begin
        skid_vld_d = 1'b1;
        skid_d = push_word_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign rsp_o.valid = head_vld_q;
  assign rsp_o.status = head_q.status;
  assign rsp_o.entry_count = head_q.entry_count;

endmodule

`default_nettype wire
